[hw/rtl/ecpr_pkg.sv]
// Shared types and codes for the enhanced clock page replacer
`timescale 1ns / 1ps

package ecpr_pkg;

   // one page reference
   typedef struct packed {
      logic [15:0] page_number;
      logic        is_write;
   } req_type;

   // frame assignment for one reference
   typedef struct packed {
      logic [2:0] frame_index;
      logic [1:0] outcome;
   } rsp_type;

   // outcome codes
   localparam logic [1:0] OUTCOME_HIT  = 2'd0;
   localparam logic [1:0] OUTCOME_FILL = 2'd1;
   localparam logic [1:0] OUTCOME_REPL = 2'd2;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SCAN_A = 5'b00100,
      ST_SCAN_B = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

[hw/rtl/ecpr_page_mem.sv]
// Page number memory: one write port, one read port, registered read data
`timescale 1ns / 1ps

module ecpr_page_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/enhanced_clock_page_replacer.sv]
// Top level of the enhanced second-chance clock page replacer
`timescale 1ns / 1ps

// Takes one page reference at a time and returns the frame that holds the page
// and whether it hit, filled a free frame or replaced a victim. Page numbers sit
// in a single-port-read memory that is searched one frame per cycle. When every
// frame is full, the search reads every frame and the victim scan then walks the
// use and modify bits one frame per cycle from the clock hand, through at most a
// clean pass, a dirty pass that clears use bits, a second clean pass, and a dirty
// pass that hits at once, with the result passing through the finish state into
// the output register.
// A new request is taken once the previous one has reached the output
// register; a waiting response does not block the next search.
module enhanced_clock_page_replacer #(
   parameter int FRAME_COUNT = 8,
   parameter int PAGE_BITS   = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ecpr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ecpr_pkg::rsp_type rsp_data
);

   import ecpr_pkg::*;

   localparam int FI_W  = $clog2(FRAME_COUNT);
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam logic [CNT_W-1:0] FRAME_TOTAL = CNT_W'(FRAME_COUNT);
   localparam logic [FI_W-1:0]  LAST_FRAME  = FI_W'(FRAME_COUNT - 1);

   // control registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [FI_W-1:0]        hand_ff, hand_in;
   logic [FRAME_COUNT-1:0] use_ff, use_in;
   logic [FRAME_COUNT-1:0] mod_ff, mod_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic                   wr_ff, wr_in;
   logic [FI_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [FI_W-1:0]        scan_ff, scan_in;
   logic [FI_W-1:0]        step_ff, step_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;

   // memory port signals
   logic                   mem_wr_en;
   logic [FI_W-1:0]        mem_wr_addr;
   logic [PAGE_BITS-1:0]   mem_wr_data;
   logic                   mem_rd_en;
   logic [FI_W-1:0]        mem_rd_addr;
   logic [PAGE_BITS-1:0]   mem_rd_data;

   logic                   req_accept;
   logic [31:0]            req_page_wide;
   logic [PAGE_BITS-1:0]   req_page;

   // ring successor of a frame
   function automatic logic [FI_W-1:0] ring_next(input logic [FI_W-1:0] f);
      if (f == LAST_FRAME) begin
         return '0;
      end else begin
         return f + 1'b1;
      end
   endfunction

   // frame number into the 3 bit result field
   function automatic logic [2:0] frame_field(input logic [FI_W-1:0] f);
      logic [63:0] wide;
      wide = 64'(f);
      return wide[2:0];
   endfunction

   // page number reduced to the stored width
   assign req_page_wide = 32'(req_data.page_number);
   assign req_page      = req_page_wide[PAGE_BITS-1:0];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   ecpr_page_mem #(
      .DEPTH (FRAME_COUNT),
      .WIDTH (PAGE_BITS)
   ) u_page_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer: search, fill, victim scan, hand-off to output register
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      hand_in      = hand_ff;
      use_in       = use_ff;
      mod_in       = mod_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      page_in      = page_ff;
      wr_in        = wr_ff;
      scan_in      = scan_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = fill_ff[FI_W-1:0];
      mem_wr_data  = page_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = issue_ff[FI_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               page_in  = req_page;
               wr_in    = req_data.is_write;
               issue_in = '0;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            if (cmp_valid_ff && (mem_rd_data == page_ff)) begin
               // hit on a filled frame
               use_in[cmp_idx_ff] = 1'b1;
               if (wr_ff) begin
                  mod_in[cmp_idx_ff] = 1'b1;
               end
               res_in.frame_index = frame_field(cmp_idx_ff);
               res_in.outcome     = OUTCOME_HIT;
               state_in           = ST_FINISH;
            end else if (issue_ff < fill_ff) begin
               // read next filled frame, compare next cycle
               mem_rd_en    = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[FI_W-1:0];
            end else if (!cmp_valid_ff) begin
               if (fill_ff != FRAME_TOTAL) begin
                  // miss with a free frame: lowest free is the fill count
                  mem_wr_en                 = 1'b1;
                  use_in[fill_ff[FI_W-1:0]] = 1'b1;
                  mod_in[fill_ff[FI_W-1:0]] = wr_ff;
                  fill_in                   = fill_ff + 1'b1;
                  res_in.frame_index        = frame_field(fill_ff[FI_W-1:0]);
                  res_in.outcome            = OUTCOME_FILL;
                  state_in                  = ST_FINISH;
               end else begin
                  scan_in  = hand_ff;
                  step_in  = '0;
                  state_in = ST_SCAN_A;
               end
            end
         end

         ST_SCAN_A: begin
            if (!use_ff[scan_ff] && !mod_ff[scan_ff]) begin
               // unused clean victim
               mem_wr_en          = 1'b1;
               mem_wr_addr        = scan_ff;
               use_in[scan_ff]    = 1'b1;
               mod_in[scan_ff]    = wr_ff;
               hand_in            = ring_next(scan_ff);
               res_in.frame_index = frame_field(scan_ff);
               res_in.outcome     = OUTCOME_REPL;
               state_in           = ST_FINISH;
            end else if (step_ff == LAST_FRAME) begin
               scan_in  = hand_ff;
               step_in  = '0;
               state_in = ST_SCAN_B;
            end else begin
               scan_in = ring_next(scan_ff);
               step_in = step_ff + 1'b1;
            end
         end

         ST_SCAN_B: begin
            if (!use_ff[scan_ff] && mod_ff[scan_ff]) begin
               // unused dirty victim
               mem_wr_en          = 1'b1;
               mem_wr_addr        = scan_ff;
               use_in[scan_ff]    = 1'b1;
               mod_in[scan_ff]    = wr_ff;
               hand_in            = ring_next(scan_ff);
               res_in.frame_index = frame_field(scan_ff);
               res_in.outcome     = OUTCOME_REPL;
               state_in           = ST_FINISH;
            end else begin
               // second chance: clear use bit as the hand passes
               use_in[scan_ff] = 1'b0;
               if (step_ff == LAST_FRAME) begin
                  scan_in  = hand_ff;
                  step_in  = '0;
                  state_in = ST_SCAN_A;
               end else begin
                  scan_in = ring_next(scan_ff);
                  step_in = step_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         hand_ff      <= '0;
         use_ff       <= '0;
         mod_ff       <= '0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         hand_ff      <= hand_in;
         use_ff       <= use_in;
         mod_ff       <= mod_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      wr_ff      <= wr_in;
      cmp_idx_ff <= cmp_idx_in;
      scan_ff    <= scan_in;
      step_ff    <= step_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // fill count never passes the frame count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FRAME_TOTAL)
      else $error("fill count beyond frame count");

   // hand stays on the ring
   a_hand_bound: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= LAST_FRAME)
      else $error("clock hand off the ring");

   // victim scan only runs with every frame filled
   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_A || state_ff == ST_SCAN_B) |-> (fill_ff == FRAME_TOTAL))
      else $error("victim scan with a free frame");

   // accepted request starts a search
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SEARCH))
      else $error("accepted request did not start a search");

   // finished result waits while the output register is held
   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("result overwrote a held response");

endmodule

[tb/page_replacer_checker.sv]
// Checker that predicts and compares frame assignments of the clock page replacer
`timescale 1ns / 1ps

module page_replacer_checker
   import ecpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   localparam int FRAMES = 8;

   // private copy of the frame table
   logic        frame_used [FRAMES];
   logic [15:0] frame_tag [FRAMES];
   logic        use_flag [FRAMES];
   logic        dirty_flag [FRAMES];
   logic [2:0]  hand;

   // frame assignments still waiting at the output
   rsp_type     expected_frames [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // enhanced clock victim scan, clean pass then dirty pass, two rounds
   function automatic int find_victim();
      int f;
      int victim;
      bit found;
      victim = 0;
      found  = 0;
      for (int round = 0; round < 2 && !found; round++) begin
         f = hand;
         for (int k = 0; k < FRAMES && !found; k++) begin
            if (!use_flag[f] && !dirty_flag[f]) begin
               found  = 1;
               victim = f;
            end else begin
               f = (f + 1) % FRAMES;
            end
         end
         f = hand;
         for (int k = 0; k < FRAMES && !found; k++) begin
            if (!use_flag[f] && dirty_flag[f]) begin
               found  = 1;
               victim = f;
            end else begin
               use_flag[f] = 1'b0;
               f = (f + 1) % FRAMES;
            end
         end
      end
      return victim;
   endfunction

   // update the table for one reference and return the frame it lands in
   function automatic rsp_type assign_frame(input req_type r);
      rsp_type res;
      int victim;
      // hit
      for (int f = 0; f < FRAMES; f++) begin
         if (frame_used[f] && frame_tag[f] == r.page_number) begin
            use_flag[f] = 1'b1;
            if (r.is_write) dirty_flag[f] = 1'b1;
            res.frame_index = 3'(f);
            res.outcome     = OUTCOME_HIT;
            return res;
         end
      end
      // lowest free frame
      for (int f = 0; f < FRAMES; f++) begin
         if (!frame_used[f]) begin
            frame_used[f] = 1'b1;
            frame_tag[f]  = r.page_number;
            use_flag[f]   = 1'b1;
            dirty_flag[f] = r.is_write;
            res.frame_index = 3'(f);
            res.outcome     = OUTCOME_FILL;
            return res;
         end
      end
      // replacement
      victim = find_victim();
      frame_tag[victim]  = r.page_number;
      use_flag[victim]   = 1'b1;
      dirty_flag[victim] = r.is_write;
      hand = 3'((victim + 1) % FRAMES);
      res.frame_index = 3'(victim);
      res.outcome     = OUTCOME_REPL;
      return res;
   endfunction

   // watch both channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int f = 0; f < FRAMES; f++) begin
            frame_used[f] = 1'b0;
            frame_tag[f]  = '0;
            use_flag[f]   = 1'b0;
            dirty_flag[f] = 1'b0;
         end
         hand = '0;
         expected_frames.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_frames.push_back(assign_frame(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected response frame %0d outcome %0d",
                                         rsp_data.frame_index, rsp_data.outcome));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_data.frame_index !== want.frame_index)
                  report_mismatch($sformatf("frame_index got %0d want %0d",
                                            rsp_data.frame_index, want.frame_index));
               if (rsp_data.outcome !== want.outcome)
                  report_mismatch($sformatf("outcome got %0d want %0d",
                                            rsp_data.outcome, want.outcome));
            end
         end
      end
      pending_count = expected_frames.size();
   end

endmodule

[tb/enhanced_clock_page_replacer_test.sv]
// Top of the clock page replacer testbench: stimulus, response pacing and verdict
`timescale 1ns / 1ps

module enhanced_clock_page_replacer_test;
   import ecpr_pkg::*;

   localparam int RANDOM_REQUESTS = 1800;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      error_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      calm = 1'b0;
   bit      hold_request = 1'b0;

   enhanced_clock_page_replacer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   page_replacer_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("enhanced_clock_page_replacer_test: done, errors");
         $finish;
      end
   end

   // offer one page reference and hold it until taken, then idle a random while unless calm
   task automatic send_page(input logic [15:0] page, input logic wr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      req_data.page_number <= page;
      req_data.is_write    <= wr;
      req_valid            <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every outstanding reference has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // response side pacing, with one long hold-off on request
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            w = calm ? 0 : $urandom_range(0, 7);
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   // stimulus
   initial begin
      logic [15:0] pool [12];
      logic [15:0] page;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fills, hits, extremes, replacement with all used and all dirty
      send_page(16'h0000, 1'b0);
      send_page(16'hFFFF, 1'b1);
      send_page(16'h0000, 1'b1);
      send_page(16'hFFFF, 1'b0);
      for (int i = 1; i <= 6; i++) send_page(16'(i), 1'(i % 2));
      send_page(16'h8000, 1'b0);
      send_page(16'h5555, 1'b1);
      send_page(16'hAAAA, 1'b0);
      send_page(16'h8000, 1'b1);
      send_page(16'h0001, 1'b0);
      for (int i = 0; i < 8; i++) send_page(16'h1000 + 16'(i), 1'b1);
      send_page(16'h7FFF, 1'b0);
      send_page(16'h7FFF, 1'b1);
      pause_until_drained();

      // random: mostly a small working set so hits and scans mix
      for (int i = 0; i < 12; i++) pool[i] = 16'($urandom);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 200 == 0)
            for (int i = 0; i < 12; i++) pool[i] = 16'($urandom);
         if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == 600) hold_request = 1'b1;
         if (n == 1200) pause_until_drained();
         if ($urandom_range(0, 99) < 85)
            page = pool[$urandom_range(0, $urandom_range(0, 1) ? 11 : 8)];
         else
            page = 16'($urandom);
         send_page(page, 1'($urandom));
      end
      req_valid <= 1'b0;

      // wait out the remaining responses
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("enhanced_clock_page_replacer_test: done, clean");
      else
         $display("enhanced_clock_page_replacer_test: done, errors");
      $finish;
   end

endmodule

[files.f]
hw/rtl/ecpr_pkg.sv
hw/rtl/ecpr_page_mem.sv
hw/rtl/enhanced_clock_page_replacer.sv
tb/page_replacer_checker.sv
tb/enhanced_clock_page_replacer_test.sv
